// File: rtl/core/lpw_pkg.sv
// Package for the line pixel walker: coordinate widths, shared types,
// controller/datapath command and status structs and the controller states.
// No dependencies.
`timescale 1ns / 1ps

package lpw_pkg;

    // Port width of every coordinate field
    localparam int FIELD_W    = 6;
    // Coordinate bits actually used (2..6); inputs are taken modulo 2^COORD_BITS
    localparam int COORD_BITS = 6;
    localparam int COLOR_W    = 32;
    // Signed difference of two coordinates
    localparam int DELTA_W    = COORD_BITS + 1;
    // Error term spans roughly -2^C .. 3*2^C
    localparam int ERR_W      = COORD_BITS + 3;

    typedef logic [FIELD_W-1:0]           t_field;
    typedef logic [COORD_BITS-1:0]        t_coord;
    typedef logic signed [DELTA_W-1:0]    t_delta;
    typedef logic [COORD_BITS:0]          t_dmin2;
    typedef logic signed [ERR_W-1:0]      t_err;
    typedef logic [COLOR_W-1:0]           t_color;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP_A,
        ST_SETUP_B,
        ST_WALK
    } t_state;

    typedef struct packed {
        logic capture;   // latch the command fields
        logic setup_a;   // find deltas and steepness
        logic setup_b;   // order endpoints, load the walker
        logic emit;      // load one pixel into the output register and advance
    } t_cmd;

    typedef struct packed {
        logic last;      // current pixel is the final one
        logic out_room;  // output register can take a pixel this cycle
    } t_status;

endpackage

// File: rtl/core/lpw_ctrl.sv
// Controller for the line pixel walker: command intake and walk sequencing.
// Depends on lpw_pkg.
`timescale 1ns / 1ps

module lpw_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  lpw_pkg::t_status i_stat,
    output lpw_pkg::t_cmd   o_cmd
);

    lpw_pkg::t_state r_state;
    lpw_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lpw_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            lpw_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = lpw_pkg::ST_SETUP_A;
                end
            end
            lpw_pkg::ST_SETUP_A: begin
                n_state = lpw_pkg::ST_SETUP_B;
            end
            lpw_pkg::ST_SETUP_B: begin
                n_state = lpw_pkg::ST_WALK;
            end
            lpw_pkg::ST_WALK: begin
                if (i_stat.out_room && i_stat.last) begin
                    n_state = lpw_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lpw_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_s_tready    = 1'b0;
        o_cmd         = '0;
        case (r_state)
            lpw_pkg::ST_IDLE: begin
                o_s_tready     = 1'b1;
                o_cmd.capture  = i_s_tvalid;
            end
            lpw_pkg::ST_SETUP_A: begin
                o_cmd.setup_a  = 1'b1;
            end
            lpw_pkg::ST_SETUP_B: begin
                o_cmd.setup_b  = 1'b1;
            end
            lpw_pkg::ST_WALK: begin
                // advance only when the output register frees up
                o_cmd.emit     = i_stat.out_room;
            end
            default: begin
                o_s_tready     = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/core/lpw_datapath.sv
// Datapath for the line pixel walker: command registers, endpoint setup,
// Bresenham step unit and the pixel output register. Depends on lpw_pkg.
`timescale 1ns / 1ps

module lpw_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lpw_pkg::t_cmd         i_cmd,
    output lpw_pkg::t_status      o_stat,
    input  lpw_pkg::t_field       i_x_start,
    input  lpw_pkg::t_field       i_y_start,
    input  lpw_pkg::t_field       i_x_end,
    input  lpw_pkg::t_field       i_y_end,
    input  lpw_pkg::t_color       i_pen_color,
    input  logic                  i_m_tready,
    output logic                  o_m_tvalid,
    output lpw_pkg::t_field       o_pixel_x,
    output lpw_pkg::t_field       o_pixel_y,
    output lpw_pkg::t_color       o_pixel_color,
    output logic                  o_last_pixel
);

    // command registers
    lpw_pkg::t_coord r_xs, r_ys, r_xe, r_ye;
    lpw_pkg::t_color r_color;
    logic            r_steep;

    // walker registers
    lpw_pkg::t_coord r_ma, r_ma_end, r_mi, r_dmaj;
    lpw_pkg::t_dmin2 r_dmin2;
    logic            r_step_up;
    lpw_pkg::t_err   r_err;

    // output register
    logic            r_out_valid;
    lpw_pkg::t_field r_px, r_py;
    lpw_pkg::t_color r_pcolor;
    logic            r_plast;

    // setup A
    lpw_pkg::t_delta w_dx, w_dy, w_adx, w_ady;
    // setup B
    lpw_pkg::t_coord w_ma0, w_mi0, w_ma1, w_mi1, w_lo_ma, w_lo_mi, w_hi_ma, w_hi_mi;
    lpw_pkg::t_delta w_dmin, w_admin;
    // step
    lpw_pkg::t_err   w_err_sum;
    logic            w_minor_step;
    logic            w_last;

    always_comb begin
        w_dx  = lpw_pkg::t_delta'(r_xe) - lpw_pkg::t_delta'(r_xs);
        w_dy  = lpw_pkg::t_delta'(r_ye) - lpw_pkg::t_delta'(r_ys);
        w_adx = w_dx[lpw_pkg::DELTA_W-1] ? -w_dx : w_dx;
        w_ady = w_dy[lpw_pkg::DELTA_W-1] ? -w_dy : w_dy;
    end

    always_comb begin
        w_ma0 = r_steep ? r_ys : r_xs;
        w_mi0 = r_steep ? r_xs : r_ys;
        w_ma1 = r_steep ? r_ye : r_xe;
        w_mi1 = r_steep ? r_xe : r_ye;
        // swap so the major coordinate rises; equal keeps the given order
        if (w_ma1 < w_ma0) begin
            w_lo_ma = w_ma1;
            w_lo_mi = w_mi1;
            w_hi_ma = w_ma0;
            w_hi_mi = w_mi0;
        end else begin
            w_lo_ma = w_ma0;
            w_lo_mi = w_mi0;
            w_hi_ma = w_ma1;
            w_hi_mi = w_mi1;
        end
        w_dmin  = lpw_pkg::t_delta'(w_hi_mi) - lpw_pkg::t_delta'(w_lo_mi);
        w_admin = w_dmin[lpw_pkg::DELTA_W-1] ? -w_dmin : w_dmin;
    end

    always_comb begin
        w_err_sum    = r_err + lpw_pkg::t_err'(r_dmin2);
        w_minor_step = w_err_sum > lpw_pkg::t_err'(r_dmaj);
        w_last       = (r_ma == r_ma_end);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_xs    <= i_x_start[lpw_pkg::COORD_BITS-1:0];
            r_ys    <= i_y_start[lpw_pkg::COORD_BITS-1:0];
            r_xe    <= i_x_end[lpw_pkg::COORD_BITS-1:0];
            r_ye    <= i_y_end[lpw_pkg::COORD_BITS-1:0];
            r_color <= i_pen_color;
        end
        if (i_cmd.setup_a) begin
            r_steep <= (w_ady > w_adx);
        end
        if (i_cmd.setup_b) begin
            r_ma      <= w_lo_ma;
            r_ma_end  <= w_hi_ma;
            r_mi      <= w_lo_mi;
            r_dmaj    <= w_hi_ma - w_lo_ma;
            r_dmin2   <= {w_admin[lpw_pkg::COORD_BITS-1:0], 1'b0};
            r_step_up <= (w_dmin > lpw_pkg::t_delta'(0));
            r_err     <= '0;
        end else if (i_cmd.emit) begin
            r_ma <= r_ma + lpw_pkg::t_coord'(1);
            if (w_minor_step) begin
                r_mi  <= r_step_up ? r_mi + lpw_pkg::t_coord'(1)
                                   : r_mi - lpw_pkg::t_coord'(1);
                r_err <= w_err_sum - lpw_pkg::t_err'({r_dmaj, 1'b0});
            end else begin
                r_err <= w_err_sum;
            end
        end
    end

    // pixel output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_px     <= lpw_pkg::t_field'(r_steep ? r_mi : r_ma);
            r_py     <= lpw_pkg::t_field'(r_steep ? r_ma : r_mi);
            r_pcolor <= r_color;
            r_plast  <= w_last;
        end
    end

    assign o_stat.last     = w_last;
    assign o_stat.out_room = !r_out_valid || i_m_tready;
    assign o_m_tvalid      = r_out_valid;
    assign o_pixel_x       = r_px;
    assign o_pixel_y       = r_py;
    assign o_pixel_color   = r_pcolor;
    assign o_last_pixel    = r_plast;

endmodule

// File: rtl/core/line_pixel_walker_top.sv
// Top level of the line pixel walker (Bresenham line rasterizer).
// Joins lpw_ctrl and lpw_datapath; depends on lpw_pkg.
//
//  channel   | dir | tdata (low bit up)                       | tlast
//  ----------+-----+------------------------------------------+-----------
//  s (line)  | in  | x_start, y_start, x_end, y_end, pen_color | -
//  m (pixel) | out | pixel_x, pixel_y, pixel_color, zero pad   | last_pixel
//
// A line of N pixels (N = major delta + 1, 1..64) passes through intake of the
// transfer, the endpoint setup states SETUP_A and SETUP_B, then one pixel per
// cycle from the single step unit while the m side has room. A new line is
// taken only once the last pixel of the previous one sits in the output register.
// Reset is synchronous, active low. A stall on the m side holds the walker.
`timescale 1ns / 1ps

module line_pixel_walker_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // x_start[5:0], y_start[11:6], x_end[17:12],
                                   // y_end[23:18], pen_color[55:24]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // pixel_x[5:0], pixel_y[11:6],
                                   // pixel_color[43:12], zero[47:44]
    output logic        m_tlast
);

    lpw_pkg::t_cmd    w_cmd;
    lpw_pkg::t_status w_stat;
    lpw_pkg::t_field  w_px, w_py;
    lpw_pkg::t_color  w_pcolor;

    lpw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    lpw_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_x_start     (s_tdata[5:0]),
        .i_y_start     (s_tdata[11:6]),
        .i_x_end       (s_tdata[17:12]),
        .i_y_end       (s_tdata[23:18]),
        .i_pen_color   (s_tdata[55:24]),
        .i_m_tready    (m_tready),
        .o_m_tvalid    (m_tvalid),
        .o_pixel_x     (w_px),
        .o_pixel_y     (w_py),
        .o_pixel_color (w_pcolor),
        .o_last_pixel  (m_tlast)
    );

    assign m_tdata = {4'b0000, w_pcolor, w_py, w_px};

`ifndef NO_ASSERTIONS
    // one line at a time: intake closes right after a transfer
    a_one_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("line accepted while a walk is in progress");

    // no pixel is emitted in SETUP_A or SETUP_B, before the first pixel
    a_setup_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !w_cmd.emit ##1 !w_cmd.emit)
        else $error("pixel emitted before endpoint setup finished");

    // the final pixel reopens intake
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit && w_stat.last) |=> (s_tready && m_tvalid && m_tlast))
        else $error("walk did not end on its last pixel");
`endif

endmodule

// File: dv/tb_line_pixel_walker_top.sv
// Self-checking testbench for line_pixel_walker_top: line commands in, pixel writes out,
// each pixel compared with an in-bench Bresenham tracer or a typed expected pixel. Depends on lpw_pkg and the RTL.
`timescale 1ns / 1ps

module tb_line_pixel_walker_top;

    typedef struct packed {
        lpw_pkg::t_field x;
        lpw_pkg::t_field y;
        lpw_pkg::t_color color;
        logic            last;
    } t_pixel;

    typedef struct {
        lpw_pkg::t_field xs;
        lpw_pkg::t_field ys;
        lpw_pkg::t_field xe;
        lpw_pkg::t_field ye;
        lpw_pkg::t_color color;
        bit              one_px;   // expected pixel typed in below
        lpw_pkg::t_field px;
        lpw_pkg::t_field py;
    } t_line_row;

    localparam int NUM_DIR    = 19;
    localparam int NUM_RANDOM = 200;
    localparam int HOLD_CYC   = 500;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;   // x_start, y_start, x_end, y_end, pen_color
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // pixel_x, pixel_y, pixel_color, zero pad
    logic        m_tlast;

    // typed expectation riding along with the offered command
    bit          tx_one_px = 1'b0;
    t_pixel      tx_pixel  = '0;

    t_pixel      pixel_q[$];
    int unsigned bad_cnt   = 0;
    bit          hold_req  = 1'b0;

    t_line_row dir_tbl [NUM_DIR] = '{
        '{6'd0,  6'd0,  6'd0,  6'd0,  32'h0000_0000, 1'b1, 6'd0,  6'd0},
        '{6'd63, 6'd63, 6'd63, 6'd63, 32'hFFFF_FFFF, 1'b1, 6'd63, 6'd63},
        '{6'd0,  6'd0,  6'd63, 6'd0,  32'h1234_5678, 1'b0, 6'd0,  6'd0},
        '{6'd63, 6'd63, 6'd0,  6'd63, 32'hFFFF_FFFF, 1'b0, 6'd0,  6'd0},
        '{6'd0,  6'd0,  6'd0,  6'd63, 32'h5555_5555, 1'b0, 6'd0,  6'd0},
        '{6'd63, 6'd63, 6'd63, 6'd0,  32'hAAAA_AAAA, 1'b0, 6'd0,  6'd0},
        '{6'd0,  6'd0,  6'd63, 6'd63, 32'h0000_0000, 1'b0, 6'd0,  6'd0},
        '{6'd63, 6'd0,  6'd0,  6'd63, 32'hDEAD_BEEF, 1'b0, 6'd0,  6'd0},
        '{6'd0,  6'd63, 6'd63, 6'd0,  32'h8000_0001, 1'b0, 6'd0,  6'd0},
        '{6'd5,  6'd2,  6'd40, 6'd17, 32'h0F0F_0F0F, 1'b0, 6'd0,  6'd0},
        '{6'd40, 6'd17, 6'd5,  6'd2,  32'hF0F0_F0F0, 1'b0, 6'd0,  6'd0},
        '{6'd10, 6'd3,  6'd20, 6'd50, 32'h0000_FFFF, 1'b0, 6'd0,  6'd0},
        '{6'd20, 6'd50, 6'd10, 6'd3,  32'hFFFF_0000, 1'b0, 6'd0,  6'd0},
        '{6'd3,  6'd60, 6'd55, 6'd58, 32'h1357_9BDF, 1'b0, 6'd0,  6'd0},
        '{6'd33, 6'd0,  6'd31, 6'd63, 32'h2468_ACE0, 1'b0, 6'd0,  6'd0},
        '{6'd7,  6'd7,  6'd8,  6'd9,  32'h7FFF_FFFF, 1'b0, 6'd0,  6'd0},
        '{6'd0,  6'd1,  6'd2,  6'd0,  32'h0000_0001, 1'b0, 6'd0,  6'd0},
        '{6'd12, 6'd12, 6'd12, 6'd12, 32'h5555_5555, 1'b1, 6'd12, 6'd12},
        '{6'd1,  6'd0,  6'd0,  6'd0,  32'hAAAA_AAAA, 1'b0, 6'd0,  6'd0}
    };

    line_pixel_walker_top u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int mag(input int v);
        return (v < 0) ? -v : v;
    endfunction

    // Append the pixel writes of one line, in emission order.
    function automatic void trace_line(input lpw_pkg::t_field xs, input lpw_pkg::t_field ys,
                                       input lpw_pkg::t_field xe, input lpw_pkg::t_field ye,
                                       input lpw_pkg::t_color color);
        int     cmask;
        int     x0, y0, x1, y1;
        int     a0, b0, a1, b1, swp;
        int     dmaj, dmin, mstep, acc, b;
        bit     steep;
        t_pixel px;
        cmask = (1 << lpw_pkg::COORD_BITS) - 1;
        x0 = int'(xs) & cmask;
        y0 = int'(ys) & cmask;
        x1 = int'(xe) & cmask;
        y1 = int'(ye) & cmask;
        steep = mag(y1 - y0) > mag(x1 - x0);
        if (steep) begin
            a0 = y0; b0 = x0; a1 = y1; b1 = x1;
        end else begin
            a0 = x0; b0 = y0; a1 = x1; b1 = y1;
        end
        // walk from the smaller major coordinate
        if (a1 < a0) begin
            swp = a0; a0 = a1; a1 = swp;
            swp = b0; b0 = b1; b1 = swp;
        end
        dmaj  = a1 - a0;
        dmin  = b1 - b0;
        mstep = (dmin > 0) ? 1 : -1;
        acc   = 0;
        b     = b0;
        for (int a = a0; a <= a1; a++) begin
            px.x     = lpw_pkg::t_field'(steep ? b : a);
            px.y     = lpw_pkg::t_field'(steep ? a : b);
            px.color = color;
            px.last  = (a == a1);
            pixel_q.push_back(px);
            acc += 2 * mag(dmin);
            if (acc > dmaj) begin
                b   += mstep;
                acc -= 2 * dmaj;
            end
        end
    endfunction

    task automatic report_bad(input string what, input t_pixel want, input t_pixel got);
        if (bad_cnt < 10)
            $display("mismatch (%0s) at %0t: want x=%0d y=%0d c=%h last=%0d, %s",
                     what, $time, want.x, want.y, want.color, want.last,
                     $sformatf("got x=%0d y=%0d c=%h last=%0d",
                               got.x, got.y, got.color, got.last));
        bad_cnt++;
    endtask

    // Record each accepted line and check each pixel transfer, in one place.
    always @(posedge i_clk) begin : pixel_check
        t_pixel got;
        t_pixel want;
        if (i_rst_n && s_tvalid && s_tready) begin
            if (tx_one_px)
                pixel_q.push_back(tx_pixel);
            else
                trace_line(s_tdata[5:0], s_tdata[11:6], s_tdata[17:12], s_tdata[23:18],
                           s_tdata[55:24]);
        end
        if (i_rst_n && m_tvalid && m_tready) begin
            got = '{m_tdata[5:0], m_tdata[11:6], m_tdata[43:12], m_tlast};
            if (pixel_q.size() == 0) begin
                report_bad("unexpected pixel", '0, got);
            end else begin
                want = pixel_q.pop_front();
                if (got != want)
                    report_bad("field", want, got);
            end
        end
    end

    // Pixel side: random ready/stall runs, plus one long hold-off on request.
    initial begin : pixel_sink
        int unsigned len;
        bit          hold_done;
        hold_done = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                hold_done = 1'b1;
                for (int c = 0; c < HOLD_CYC; c++) @(posedge i_clk);
            end else if ($urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                len = $urandom_range(0, 99);
                if (len < 70)      len = $urandom_range(1, 3);
                else if (len < 95) len = $urandom_range(4, 10);
                else               len = $urandom_range(20, 40);
                repeat (len) @(posedge i_clk);
            end else begin
                m_tready <= 1'b1;
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                  : $urandom_range(1, 30);
                repeat (len) @(posedge i_clk);
            end
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(30, 60);
    endfunction

    function automatic lpw_pkg::t_field near(input lpw_pkg::t_field c);
        int v;
        v = int'(c) + int'($urandom_range(0, 14)) - 7;
        if (v < 0)  v = 0;
        if (v > 63) v = 63;
        return lpw_pkg::t_field'(v);
    endfunction

    // Offer one line and hold it until the transfer, then idle for the gap if it is nonzero.
    task automatic offer_line(input lpw_pkg::t_field xs, input lpw_pkg::t_field ys,
                              input lpw_pkg::t_field xe, input lpw_pkg::t_field ye,
                              input lpw_pkg::t_color color, input bit one_px,
                              input lpw_pkg::t_field px, input lpw_pkg::t_field py,
                              input int unsigned gap);
        s_tdata   <= {color, ye, xe, ys, xs};
        s_tvalid  <= 1'b1;
        tx_one_px <= one_px;
        tx_pixel  <= '{px, py, color, 1'b1};
        do @(posedge i_clk); while (!s_tready);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin : line_source
        lpw_pkg::t_field xs, ys, xe, ye;
        lpw_pkg::t_color color;
        int unsigned     kind, d, gap;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tbl[i])
            offer_line(dir_tbl[i].xs, dir_tbl[i].ys, dir_tbl[i].xe, dir_tbl[i].ye,
                       dir_tbl[i].color, dir_tbl[i].one_px, dir_tbl[i].px, dir_tbl[i].py,
                       pick_gap());

        for (int n = 0; n < NUM_RANDOM; n++) begin
            kind  = $urandom_range(0, 9);
            color = $urandom;
            xs    = lpw_pkg::t_field'($urandom_range(0, 63));
            ys    = lpw_pkg::t_field'($urandom_range(0, 63));
            if (kind < 6) begin
                xe = lpw_pkg::t_field'($urandom_range(0, 63));
                ye = lpw_pkg::t_field'($urandom_range(0, 63));
            end else if (kind < 9) begin
                xe = near(xs);
                ye = near(ys);
            end else begin
                case ($urandom_range(0, 2))
                    0: begin
                        xe = xs;
                        ye = lpw_pkg::t_field'($urandom_range(0, 63));
                    end
                    1: begin
                        ye = ys;
                        xe = lpw_pkg::t_field'($urandom_range(0, 63));
                    end
                    default: begin
                        d  = $urandom_range(0, 63);
                        xs = lpw_pkg::t_field'($urandom_range(0, 63 - d));
                        ys = lpw_pkg::t_field'($urandom_range(0, 63 - d));
                        xe = xs + lpw_pkg::t_field'(d);
                        ye = ys + lpw_pkg::t_field'(d);
                        // mirror for the falling diagonal
                        if ($urandom_range(0, 1) == 1) begin
                            ye = ys;
                            ys = ys + lpw_pkg::t_field'(d);
                        end
                    end
                endcase
            end

            // keep offering back to back while the pixel side holds off
            if (n == 20) hold_req = 1'b1;
            gap = (n >= 20 && n < 40) ? 0 : pick_gap();
            offer_line(xs, ys, xe, ye, color, 1'b0, '0, '0, gap);

            if (n == 100) begin
                s_tvalid <= 1'b0;
                // let the last transfer reach the queue before draining
                @(posedge i_clk);
                while (pixel_q.size() != 0) @(posedge i_clk);
            end
        end

        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (bad_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
